[hdl/fa_pkg.sv]
// Package for the fraction ALU: widths, operation codes, item structs and the
// status struct shared by the iterative units. No dependencies.
`default_nettype none
package fa_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  localparam int NUM_BITS     = PROD_BITS + 1;
  localparam int DEN_BITS     = PROD_BITS;
  localparam int MAG_BITS     = PROD_BITS;
  localparam int SHIFT_BITS   = $clog2(MAG_BITS);
  localparam int CNT_BITS     = $clog2(MAG_BITS);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fa_op_t;

  typedef struct packed {
    fa_op_t                         req_type;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic signed [OPERAND_BITS-1:0] a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic signed [OPERAND_BITS-1:0] b_den;
  } fa_in_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] res_num;
    logic signed [DEN_BITS-1:0] res_den;
  } fa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fa_sts_t;

endpackage
`default_nettype wire

[hdl/fa_mul.sv]
// Registered signed multiplier, shared by all cross products of an item.
// Depends on fa_pkg.
`default_nettype none
module fa_mul (
  input  logic                                 clk,
  input  logic signed [fa_pkg::OPERAND_BITS-1:0] a,
  input  logic signed [fa_pkg::OPERAND_BITS-1:0] b,
  output logic signed [fa_pkg::PROD_BITS-1:0]    p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

[hdl/fa_gcd.sv]
// Binary gcd unit: one shift or subtract per cycle. Returns 1 when either
// operand is zero. Depends on fa_pkg.
`default_nettype none
module fa_gcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fa_pkg::MAG_BITS-1:0]   a,
  input  logic [fa_pkg::MAG_BITS-1:0]   b,
  output logic [fa_pkg::MAG_BITS-1:0]   g_r,
  output fa_pkg::fa_sts_t               sts
);

  logic [fa_pkg::MAG_BITS-1:0]   x_r, x_nxt, y_r, y_nxt, g_nxt;
  logic [fa_pkg::SHIFT_BITS-1:0] k_r, k_nxt;
  logic                          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      if (a == '0 || b == '0) begin
        g_nxt    = fa_pkg::MAG_BITS'(1);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        x_nxt    = a;
        y_nxt    = b;
        k_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      priority if (y_r == '0) begin
        g_nxt    = x_r << k_r;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (!x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_nxt = x_r >> 1;
      end else if (!y_r[0]) begin
        y_nxt = y_r >> 1;
      end else if (x_r > y_r) begin
        x_nxt = x_r - y_r;
      end else begin
        y_nxt = y_r - x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

[hdl/fa_div.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on fa_pkg.
`default_nettype none
module fa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fa_pkg::MAG_BITS-1:0] dividend,
  input  logic [fa_pkg::MAG_BITS-1:0] divisor,
  output logic [fa_pkg::MAG_BITS-1:0] quo_r,
  output fa_pkg::fa_sts_t             sts
);

  logic [fa_pkg::MAG_BITS:0]     rem_r, rem_nxt, trial, diff;
  logic [fa_pkg::MAG_BITS-1:0]   quo_nxt, dvs_r, dvs_nxt;
  logic [fa_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt, done_r, done_nxt;

  assign trial = {rem_r[fa_pkg::MAG_BITS-1:0], quo_r[fa_pkg::MAG_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[fa_pkg::MAG_BITS]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[fa_pkg::MAG_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[fa_pkg::MAG_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == fa_pkg::CNT_BITS'(fa_pkg::MAG_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

[hdl/fraction_alu_with_reduction_top.sv]
// Fraction ALU top level: sequencer around the shared multiplier, the binary
// gcd unit and the bit-serial divider. Depends on fa_pkg, fa_mul, fa_gcd, fa_div.
//
// One item at a time: the three cross products go through one multiplier in
// turn, then the numerator (the sum or difference for add and subtract) is
// formed, the binary gcd loop runs one shift or subtract at a time, and the
// numerator and denominator are then divided by the gcd in two passes through
// the bit-serial divider. The result sits in an output register, so the next
// item is taken while it waits.
`default_nettype none
module fraction_alu_with_reduction_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fa_pkg::fa_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fa_pkg::fa_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_GSTART, S_GCD, S_NSTART, S_DIVN, S_DSTART, S_DIVD, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  fa_pkg::fa_in_t item_r, item_nxt;
  logic [1:0] mstep_r, mstep_nxt;
  logic signed [fa_pkg::PROD_BITS-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [fa_pkg::NUM_BITS-1:0]  num_r, num_nxt;
  logic signed [fa_pkg::DEN_BITS-1:0]  den_r, den_nxt;
  logic [fa_pkg::MAG_BITS-1:0]         g_r, g_nxt, qn_r, qn_nxt;
  logic [fa_pkg::MAG_BITS-1:0]         num_mag, den_mag;
  fa_pkg::fa_out_t                     out_r, out_nxt;
  logic                                out_valid_r, out_valid_nxt;

  logic signed [fa_pkg::OPERAND_BITS-1:0] mul_a, mul_b;
  logic signed [fa_pkg::PROD_BITS-1:0]    mul_p;
  logic                                   gcd_start, div_start;
  logic [fa_pkg::MAG_BITS-1:0]            gcd_g, div_q, div_dividend;
  fa_pkg::fa_sts_t                        gcd_sts, div_sts;

  always_comb begin
    unique case (mstep_r)
      2'd0: begin
        mul_a = item_r.a_num;
        mul_b = (item_r.req_type == fa_pkg::OP_MUL) ? item_r.b_num : item_r.b_den;
      end
      2'd1: begin
        mul_a = item_r.a_den;
        mul_b = (item_r.req_type == fa_pkg::OP_DIV) ? item_r.b_num : item_r.b_den;
      end
      default: begin
        mul_a = item_r.b_num;
        mul_b = item_r.a_den;
      end
    endcase
  end

  fa_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign num_mag = num_r[fa_pkg::NUM_BITS-1] ? fa_pkg::MAG_BITS'(-num_r)
                                             : fa_pkg::MAG_BITS'(num_r);
  assign den_mag = den_r[fa_pkg::DEN_BITS-1] ? fa_pkg::MAG_BITS'(-den_r)
                                             : fa_pkg::MAG_BITS'(den_r);

  assign gcd_start    = (state_r == S_GSTART);
  assign div_start    = (state_r == S_NSTART) || (state_r == S_DSTART);
  assign div_dividend = (state_r == S_NSTART) ? num_mag : den_mag;

  fa_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a     (num_mag),
    .b     (den_mag),
    .g_r   (gcd_g),
    .sts   (gcd_sts)
  );

  fa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .quo_r    (div_q),
    .sts      (div_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    mstep_nxt     = mstep_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    g_nxt         = g_r;
    qn_nxt        = qn_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          mstep_nxt = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        unique case (mstep_r)
          2'd0: ;
          2'd1: p0_nxt = mul_p;
          2'd2: p1_nxt = mul_p;
          default: begin
            p2_nxt    = mul_p;
            state_nxt = S_SUM;
          end
        endcase
      end
      S_SUM: begin
        unique case (item_r.req_type)
          fa_pkg::OP_ADD: num_nxt = fa_pkg::NUM_BITS'(p0_r) + fa_pkg::NUM_BITS'(p2_r);
          fa_pkg::OP_SUB: num_nxt = fa_pkg::NUM_BITS'(p0_r) - fa_pkg::NUM_BITS'(p2_r);
          default:        num_nxt = fa_pkg::NUM_BITS'(p0_r);
        endcase
        den_nxt   = p1_r;
        state_nxt = S_GSTART;
      end
      S_GSTART: state_nxt = S_GCD;
      S_GCD: begin
        if (gcd_sts.done) begin
          g_nxt     = gcd_g;
          state_nxt = S_NSTART;
        end
      end
      S_NSTART: state_nxt = S_DIVN;
      S_DIVN: begin
        if (div_sts.done) begin
          qn_nxt    = div_q;
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: state_nxt = S_DIVD;
      S_DIVD: begin
        if (div_sts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // divider quotient holds until the next start
        if (!out_valid_r || !out_stall) begin
          out_nxt.res_num = num_r[fa_pkg::NUM_BITS-1] ? -{1'b0, qn_r} : {1'b0, qn_r};
          out_nxt.res_den = den_r[fa_pkg::DEN_BITS-1] ? -div_q : div_q;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mstep_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    g_r    <= g_nxt;
    qn_r   <= qn_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted but block not busy next cycle");

  a_gcd_when: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_sts.done |-> (state_r == S_GCD))
    else $error("gcd finished outside gcd wait");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_sts.done |-> (gcd_g != '0))
    else $error("gcd result is zero");

  a_div_when: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIVN || state_r == S_DIVD))
    else $error("divider finished outside divide wait");

  a_gcd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_sts.busy |-> (state_r == S_GCD))
    else $error("gcd busy outside gcd wait");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == S_DIVN || state_r == S_DIVD))
    else $error("divider busy outside divide wait");

endmodule
`default_nettype wire

[test/tb_fraction_alu_with_reduction_top.sv]
// Self-checking bench for fraction_alu_with_reduction_top: a directed table, then random
// fraction items under random valid/stall idling, checked against a gcd-reduction predictor.
// Depends on fa_pkg and the top-level RTL only.
`default_nettype none
module tb_fraction_alu_with_reduction_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 1700;
  localparam int HOLD_CYCLES = 900;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 300;

  typedef struct {
    fa_pkg::fa_op_t op;
    int             an, ad, bn, bd;
    bit             typed;
    longint         en, ed;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  fa_pkg::fa_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  fa_pkg::fa_out_t out_data;

  fa_pkg::fa_out_t ratio_q[$];
  dir_row_t        dir_rows[$];
  int              errors = 0;
  int              items_sent = 0;
  int              results_seen = 0;
  bit              calm = 1'b0;
  bit              hold_go = 1'b0;

  fraction_alu_with_reduction_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic fa_pkg::fa_out_t pack_ratio(longint n, longint d);
    fa_pkg::fa_out_t o;
    o.res_num = n[fa_pkg::NUM_BITS-1:0];
    o.res_den = d[fa_pkg::DEN_BITS-1:0];
    return o;
  endfunction

  // cross multiply, then divide both parts by gcd(|num|,|den|), or 1 if either is zero
  function automatic fa_pkg::fa_out_t reduce_fraction(fa_pkg::fa_in_t it);
    longint an, ad, bn, bd, num, den, x, y, r;
    an = longint'($signed(it.a_num));
    ad = longint'($signed(it.a_den));
    bn = longint'($signed(it.b_num));
    bd = longint'($signed(it.b_den));
    case (it.req_type)
      fa_pkg::OP_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      fa_pkg::OP_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      fa_pkg::OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    x = (num < 0) ? -num : num;
    y = (den < 0) ? -den : den;
    if (x == 0 || y == 0) begin
      x = 1;
    end else begin
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
    end
    return pack_ratio(num / x, den / x);
  endfunction

  function automatic logic [fa_pkg::OPERAND_BITS-1:0] rand_operand();
    int sel, v;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      v = $urandom();
    end else if (sel < 65) begin
      v = $urandom_range(0, 40) - 20;
    end else if (sel < 80) begin
      case ($urandom_range(0, 5))
        0: v = -32768;
        1: v = -32767;
        2: v = -1;
        3: v = 0;
        4: v = 1;
        default: v = 32767;
      endcase
    end else begin
      v = ($urandom_range(0, 14) - 7) <<< $urandom_range(0, 13);
    end
    return v[fa_pkg::OPERAND_BITS-1:0];
  endfunction

  task automatic add_row(fa_pkg::fa_op_t op, int an, int ad, int bn, int bd,
                         bit typed = 1'b0, longint en = 0, longint ed = 0);
    dir_row_t r;
    r.op = op;
    r.an = an;
    r.ad = ad;
    r.bn = bn;
    r.bd = bd;
    r.typed = typed;
    r.en = en;
    r.ed = ed;
    dir_rows.push_back(r);
  endtask

  // called right after a posedge; returns at the edge where the item is taken
  task automatic send_item(fa_pkg::fa_in_t it, fa_pkg::fa_out_t want);
    bit idle;
    idle = !calm && ($urandom_range(0, 99) < 27);
    if (idle) begin
      in_valid <= 1'b0;
      while (idle) begin
        @(posedge clk);
        idle = !calm && ($urandom_range(0, 99) < 27);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    ratio_q.push_back(want);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (ratio_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic report(string what, fa_pkg::fa_out_t want, fa_pkg::fa_out_t got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d/%0d, actual %0d/%0d", $time, what,
             want.res_num, want.res_den, got.res_num, got.res_den);
  endtask

  task automatic check_result(fa_pkg::fa_out_t got);
    fa_pkg::fa_out_t want;
    results_seen++;
    if (ratio_q.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected item, expected none, actual %0d/%0d", $time,
               got.res_num, got.res_den);
      return;
    end
    want = ratio_q.pop_front();
    if (got.res_num !== want.res_num) report("res_num", want, got);
    if (got.res_den !== want.res_den) report("res_den", want, got);
  endtask

  initial begin : result_side
    int  hold_cnt;
    bit  hold_used;
    hold_cnt  = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_result(out_data);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no item moved for %0d cycles", $time, WDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    fa_pkg::fa_in_t  it;
    fa_pkg::fa_out_t want;
    add_row(fa_pkg::OP_ADD, 0, 1, 0, 1, 1, 0, 1);
    add_row(fa_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 4);
    add_row(fa_pkg::OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1);
    add_row(fa_pkg::OP_MUL, 32767, 1, 32767, 1, 1, 1073676289, 1);
    add_row(fa_pkg::OP_MUL, 1, -32768, 1, -32768, 1, 1, 1073741824);
    add_row(fa_pkg::OP_DIV, 1, -32768, -32768, 1, 1, 1, 1073741824);
    add_row(fa_pkg::OP_ADD, -32768, -32768, -32768, -32768, 1, 2, 1);
    add_row(fa_pkg::OP_SUB, -32768, -32768, 32767, -32768);
    add_row(fa_pkg::OP_ADD, -32768, 1, -32768, 1, 1, -65536, 1);
    add_row(fa_pkg::OP_ADD, 32767, 32767, 32767, -32768);
    add_row(fa_pkg::OP_MUL, 3, 0, 5, 7, 1, 15, 0);
    add_row(fa_pkg::OP_DIV, 3, 4, 0, 5, 1, 15, 0);
    add_row(fa_pkg::OP_MUL, 0, 0, 0, 0, 1, 0, 0);
    add_row(fa_pkg::OP_MUL, -2, 4, 3, 1, 1, -3, 2);
    add_row(fa_pkg::OP_MUL, 1, -2, 1, 3, 1, 1, -6);
    add_row(fa_pkg::OP_DIV, -6, 5, -3, 10, 1, -4, -1);
    add_row(fa_pkg::OP_ADD, 1, 6, 1, 3, 1, 1, 2);
    add_row(fa_pkg::OP_SUB, 0, 5, 3, 0, 1, -15, 0);
    add_row(fa_pkg::OP_ADD, -1, -1, -1, -1, 1, 2, 1);
    add_row(fa_pkg::OP_DIV, 32767, -32768, -32768, 32767, 1, 1073676289, 1073741824);
    add_row(fa_pkg::OP_SUB, 12345, -32768, -32768, 777);
    add_row(fa_pkg::OP_ADD, 32767, -1, 32767, -1, 1, -65534, 1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.req_type = dir_rows[i].op;
      it.a_num    = dir_rows[i].an[fa_pkg::OPERAND_BITS-1:0];
      it.a_den    = dir_rows[i].ad[fa_pkg::OPERAND_BITS-1:0];
      it.b_num    = dir_rows[i].bn[fa_pkg::OPERAND_BITS-1:0];
      it.b_den    = dir_rows[i].bd[fa_pkg::OPERAND_BITS-1:0];
      want = dir_rows[i].typed ? pack_ratio(dir_rows[i].en, dir_rows[i].ed)
                               : reduce_fraction(it);
      send_item(it, want);
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_go = 1'b1;
      calm = (n >= 600 && n < 850);
      if (n == 1000 || n == 1500) drain_results();
      it.req_type = fa_pkg::fa_op_t'($urandom_range(0, 3));
      it.a_num    = rand_operand();
      it.a_den    = rand_operand();
      it.b_num    = rand_operand();
      it.b_den    = rand_operand();
      send_item(it, reduce_fraction(it));
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (ratio_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d directed and %0d random fraction items, %0d results checked,",
             dir_rows.size(), N_RANDOM, results_seen);
    $display("with random idling, one long output hold-off and two full drains.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
